// ----- hw/rtl/supply_link_frame_controller_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Supply link frame controller: assertion macros
// Shared concurrent assertion forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef SUPPLY_LINK_FRAME_CONTROLLER_UNIT_MACROS_SVH
`define SUPPLY_LINK_FRAME_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define SLFC_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("slfc: same-cycle check failed");

// next-cycle implication, held off during reset
`define SLFC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("slfc: next-cycle check failed");

`endif

// ----- hw/rtl/slfc_pkg.sv -----
// ---------------------------------------------------------------------------
// Supply link frame controller package
// Widths, reset values, phase and register codes, and the job record.
// ---------------------------------------------------------------------------
`default_nettype none

package slfc_pkg;

	localparam int RX_W       = 8;
	localparam int SAMPLE_W   = 10;
	localparam int VOLT_W     = 16;
	localparam int THRESH_W   = 9;
	localparam int GAIN_W     = 8;
	localparam int SCALED_W   = 9;
	localparam int PWM_W      = 8;
	localparam int SETPOINT_W = 16;
	localparam int FLAG_W     = 5;
	localparam int POLL_W     = 4;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [RX_W-1:0]     SYNC_RESET   = 8'h42;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd20;
	localparam logic [GAIN_W-1:0]   GAIN_RESET   = 8'd192;

	localparam int CURRENT_SCALE = 35;
	localparam int CURRENT_SHIFT = 7;
	localparam int SCALE_W       = 6;

	// command flag bit positions
	localparam int FLAG_MAIN = 0;
	localparam int FLAG_AUTO = 1;
	localparam int FLAG_IGN  = 2;
	localparam int FLAG_HV   = 3;
	localparam int FLAG_SIM  = 4;

	localparam int JOB_FIFO_DEPTH = 2;
	localparam int TX_MAX         = 3;

	typedef enum logic [3:0] {
		PH_SYNC         = 4'd0,
		PH_CMD_FIRST    = 4'd1,
		PH_CMD_SECOND   = 4'd2,
		PH_CHECK_FIRST  = 4'd3,
		PH_CHECK_SECOND = 4'd4,
		PH_SET_LOW      = 4'd5,
		PH_SET_HIGH     = 4'd6,
		PH_SKIP_0       = 4'd7,
		PH_SKIP_1       = 4'd8,
		PH_SKIP_2       = 4'd9,
		PH_SKIP_3       = 4'd10,
		PH_POLL         = 4'd11,
		PH_TAIL         = 4'd12
	} slfc_phase_t;

	typedef enum logic [POLL_W-1:0] {
		POLL_CURRENT = 4'd0,
		POLL_VOLTAGE = 4'd1
	} slfc_poll_t;

	typedef enum logic [1:0] {
		REG_SYNC_VALUE    = 2'd0,
		REG_IGN_THRESHOLD = 2'd1,
		REG_PWM_GAIN      = 2'd2
	} slfc_reg_t;

	typedef struct packed {
		logic [RX_W-1:0]     sync_value;
		logic [THRESH_W-1:0] ign_threshold;
		logic [GAIN_W-1:0]   pwm_gain;
	} slfc_cfg_t;

	typedef struct packed {
		logic                main_enable;
		logic                auto_mode;
		logic                simmer_supply_on;
		logic                hv_supply_on;
		logic                ignition_detected;
		logic                ignite_pulse;
		logic [PWM_W-1:0]    pwm_compare;
		logic [SCALED_W-1:0] scaled_current;
	} slfc_status_t;

	typedef struct packed {
		logic [1:0]                 last_idx;
		logic                       tx_valid;
		logic [TX_MAX-1:0][RX_W-1:0] tx;
		slfc_status_t               status;
	} slfc_job_t;

endpackage

`default_nettype wire

// ----- hw/rtl/slfc_in_if.sv -----
// ---------------------------------------------------------------------------
// Supply link frame controller: request channel
// Received byte with current and voltage samples, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface slfc_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  rx_byte;
	logic [9:0]  current_sample;
	logic [15:0] voltage_sample;

	modport source (output valid, rx_byte, current_sample, voltage_sample, input ready);
	modport sink (input valid, rx_byte, current_sample, voltage_sample, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/slfc_out_if.sv -----
// ---------------------------------------------------------------------------
// Supply link frame controller: result channel
// Reply byte plus supply status, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface slfc_out_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       tx_last;
	logic       main_enable;
	logic       auto_mode;
	logic       simmer_supply_on;
	logic       hv_supply_on;
	logic       ignition_detected;
	logic       ignite_pulse;
	logic [7:0] pwm_compare;
	logic [8:0] scaled_current;

	modport source (output valid, tx_valid, tx_byte, tx_last, main_enable, auto_mode,
		simmer_supply_on, hv_supply_on, ignition_detected, ignite_pulse, pwm_compare,
		scaled_current, input ready);
	modport sink (input valid, tx_valid, tx_byte, tx_last, main_enable, auto_mode,
		simmer_supply_on, hv_supply_on, ignition_detected, ignite_pulse, pwm_compare,
		scaled_current, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/slfc_front.sv -----
// ---------------------------------------------------------------------------
// Supply link frame controller: frame parser
// Takes requests, steps the frame phases, and builds one reply job each.
// ---------------------------------------------------------------------------
`default_nettype none

module slfc_front #(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	slfc_in_if.sink                in_ch,
	input  wire slfc_pkg::slfc_cfg_t cfg,
	output logic                   push_valid,
	input  wire logic              push_ready,
	output slfc_pkg::slfc_job_t    push_job
);
	import slfc_pkg::*;

	localparam int USED_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << USED_BITS) - 1);
	localparam int PROD_W = SAMPLE_W + SCALE_W;
	localparam int PWM_PROD_W = SETPOINT_W + GAIN_W;

	slfc_phase_t           phase_q, phase_n;
	logic [RX_W-1:0]       cmd_first_q, cmd_first_n;
	logic [RX_W-1:0]       cmd_second_q, cmd_second_n;
	logic [RX_W-1:0]       check_first_q, check_first_n;
	logic [RX_W-1:0]       set_low_q, set_low_n;
	logic [SETPOINT_W-1:0] setpoint_q, setpoint_n;
	logic [FLAG_W-1:0]     flags_q, flags_n;
	logic                  prev_ign_q;

	logic                  accept;
	logic [RX_W-1:0]       rx;
	logic [SAMPLE_W-1:0]   sample;
	logic [PROD_W-1:0]     cur_prod;
	logic [SCALED_W-1:0]   scaled;
	logic                  ign_det;
	logic [PWM_PROD_W-1:0] pwm_prod;
	logic [POLL_W-1:0]     poll;
	logic [VOLT_W-1:0]     reply_value;
	logic                  main_on;

	assign accept       = in_ch.valid && push_ready;
	assign in_ch.ready  = push_ready;
	assign push_valid   = in_ch.valid;

	assign rx       = in_ch.rx_byte;
	assign sample   = in_ch.current_sample & SAMPLE_MASK;
	assign cur_prod = PROD_W'(sample) * PROD_W'(CURRENT_SCALE);
	assign scaled   = cur_prod[CURRENT_SHIFT +: SCALED_W];
	assign ign_det  = (scaled > cfg.ign_threshold);
	assign poll     = rx[POLL_W-1:0];
	assign main_on  = flags_q[FLAG_MAIN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SYNC;
			cmd_first_q   <= '0;
			cmd_second_q  <= '0;
			check_first_q <= '0;
			set_low_q     <= '0;
			setpoint_q    <= '0;
			flags_q       <= '0;
			prev_ign_q    <= 1'b0;
		end else if (accept) begin
			phase_q       <= phase_n;
			cmd_first_q   <= cmd_first_n;
			cmd_second_q  <= cmd_second_n;
			check_first_q <= check_first_n;
			set_low_q     <= set_low_n;
			setpoint_q    <= setpoint_n;
			flags_q       <= flags_n;
			prev_ign_q    <= flags_n[FLAG_IGN];
		end
	end

	always_comb begin
		phase_n       = phase_q;
		cmd_first_n   = cmd_first_q;
		cmd_second_n  = cmd_second_q;
		check_first_n = check_first_q;
		set_low_n     = set_low_q;
		setpoint_n    = setpoint_q;
		flags_n       = flags_q;
		push_job      = '0;
		reply_value   = '0;
		case (phase_q)
			PH_SYNC: begin
				if (rx == cfg.sync_value)
					phase_n = PH_CMD_FIRST;
			end
			PH_CMD_FIRST: begin
				cmd_first_n = rx;
				phase_n     = PH_CMD_SECOND;
			end
			PH_CMD_SECOND: begin
				cmd_second_n = rx;
				phase_n      = PH_CHECK_FIRST;
			end
			PH_CHECK_FIRST: begin
				check_first_n = rx;
				phase_n       = PH_CHECK_SECOND;
			end
			PH_CHECK_SECOND: begin
				// both commands must match their complemented check bytes
				if (cmd_first_q == ~check_first_q && cmd_second_q == ~rx)
					flags_n = cmd_first_q[FLAG_W-1:0];
				phase_n = PH_SET_LOW;
			end
			PH_SET_LOW: begin
				set_low_n = rx;
				phase_n   = PH_SET_HIGH;
			end
			PH_SET_HIGH: begin
				setpoint_n = {rx, set_low_q};
				phase_n    = PH_SKIP_0;
			end
			PH_SKIP_0: phase_n = PH_SKIP_1;
			PH_SKIP_1: phase_n = PH_SKIP_2;
			PH_SKIP_2: phase_n = PH_SKIP_3;
			PH_SKIP_3: phase_n = PH_POLL;
			PH_POLL: begin
				push_job.tx_valid = 1'b1;
				push_job.tx[0]    = {5'b0, main_on && flags_q[FLAG_SIM], ign_det,
					main_on && flags_q[FLAG_HV]};
				if (poll == POLL_CURRENT || poll == POLL_VOLTAGE) begin
					reply_value       = (poll == POLL_CURRENT) ? VOLT_W'(scaled)
						: in_ch.voltage_sample;
					push_job.last_idx = 2'd2;
					push_job.tx[1]    = reply_value[7:0];
					push_job.tx[2]    = reply_value[15:8];
				end
				phase_n = PH_TAIL;
			end
			PH_TAIL: phase_n = PH_SYNC;
			default: phase_n = PH_SYNC;
		endcase

		pwm_prod = PWM_PROD_W'(setpoint_n) * PWM_PROD_W'(cfg.pwm_gain);
		push_job.status.main_enable       = flags_n[FLAG_MAIN];
		push_job.status.auto_mode         = flags_n[FLAG_AUTO];
		push_job.status.simmer_supply_on  = flags_n[FLAG_MAIN] && flags_n[FLAG_SIM];
		push_job.status.hv_supply_on      = flags_n[FLAG_MAIN] && flags_n[FLAG_HV];
		push_job.status.ignition_detected = ign_det;
		push_job.status.ignite_pulse      = flags_n[FLAG_IGN] && !prev_ign_q;
		push_job.status.pwm_compare       = pwm_prod[PWM_W +: PWM_W];
		push_job.status.scaled_current    = scaled;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/slfc_job_fifo.sv -----
// ---------------------------------------------------------------------------
// Supply link frame controller: job queue
// Short queue between the frame parser and the reply sender.
// ---------------------------------------------------------------------------
`default_nettype none

module slfc_job_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_valid,
	output logic                     push_ready,
	input  wire slfc_pkg::slfc_job_t push_job,
	output logic                     pop_valid,
	input  wire logic                pop_ready,
	output slfc_pkg::slfc_job_t      pop_job
);
	import slfc_pkg::*;

	localparam int PTR_W = (JOB_FIFO_DEPTH > 1) ? $clog2(JOB_FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(JOB_FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(JOB_FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(JOB_FIFO_DEPTH);

	slfc_job_t        entries_q [JOB_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_job    = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= push_job;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/slfc_back.sv -----
// ---------------------------------------------------------------------------
// Supply link frame controller: reply sender
// Unrolls each job into one or three results behind an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module slfc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                pop_valid,
	output logic                     pop_ready,
	input  wire slfc_pkg::slfc_job_t pop_job,
	slfc_out_if.source               out_ch
);
	import slfc_pkg::*;

	logic             out_valid_q;
	logic [1:0]       idx_q;
	logic             tx_valid_q;
	logic [RX_W-1:0]  tx_byte_q;
	logic             tx_last_q;
	slfc_status_t     status_q;
	logic             load;
	logic             last_item;

	assign load      = pop_valid && (!out_valid_q || out_ch.ready);
	assign last_item = (idx_q == pop_job.last_idx);
	assign pop_ready = load && last_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last_item ? 2'd0 : idx_q + 2'd1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tx_valid_q <= pop_job.tx_valid;
			tx_byte_q  <= pop_job.tx[idx_q];
			tx_last_q  <= last_item;
			status_q   <= pop_job.status;
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.tx_valid          = tx_valid_q;
	assign out_ch.tx_byte           = tx_byte_q;
	assign out_ch.tx_last           = tx_last_q;
	assign out_ch.main_enable       = status_q.main_enable;
	assign out_ch.auto_mode         = status_q.auto_mode;
	assign out_ch.simmer_supply_on  = status_q.simmer_supply_on;
	assign out_ch.hv_supply_on      = status_q.hv_supply_on;
	assign out_ch.ignition_detected = status_q.ignition_detected;
	assign out_ch.ignite_pulse      = status_q.ignite_pulse;
	assign out_ch.pwm_compare       = status_q.pwm_compare;
	assign out_ch.scaled_current    = status_q.scaled_current;

endmodule

`default_nettype wire

// ----- hw/rtl/supply_link_frame_controller_unit.sv -----
// ---------------------------------------------------------------------------
// Supply link frame controller unit
// Frame parser, job queue and reply sender with an APB register port.
// ---------------------------------------------------------------------------
// Each request (one received byte plus current and voltage samples) is taken
// by the frame parser and turned into a job; the reply sender emits one
// result per cycle from a two-entry job queue unless the output stalls. A
// non-poll byte gives one result, so such requests are taken every cycle
// unless the output stalls; a poll byte for current or voltage gives three
// results and holds the result side until all three are out, which sets the
// sustained rate on poll frames. Registers at byte addresses 0 (sync value),
// 4 (ignition threshold) and 8 (PWM gain); write them only while the block is
// idle. Output flags reflect the state after the request that caused them.
`default_nettype none

module supply_link_frame_controller_unit #(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	slfc_in_if.sink                              in_ch,
	slfc_out_if.source                           out_ch,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [slfc_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [slfc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [slfc_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready
);
	import slfc_pkg::*;

	slfc_cfg_t  cfg_q;
	logic       cfg_write;
	logic [1:0] reg_idx;
	logic       push_valid;
	logic       push_ready;
	slfc_job_t  push_job;
	logic       pop_valid;
	logic       pop_ready;
	slfc_job_t  pop_job;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[APB_ADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_value    <= SYNC_RESET;
			cfg_q.ign_threshold <= THRESH_RESET;
			cfg_q.pwm_gain      <= GAIN_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_SYNC_VALUE:    cfg_q.sync_value    <= pwdata[RX_W-1:0];
				REG_IGN_THRESHOLD: cfg_q.ign_threshold <= pwdata[THRESH_W-1:0];
				REG_PWM_GAIN:      cfg_q.pwm_gain      <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SYNC_VALUE:    prdata = APB_DATA_W'(cfg_q.sync_value);
			REG_IGN_THRESHOLD: prdata = APB_DATA_W'(cfg_q.ign_threshold);
			REG_PWM_GAIN:      prdata = APB_DATA_W'(cfg_q.pwm_gain);
			default:           prdata = '0;
		endcase
	end

	slfc_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	slfc_job_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	slfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/slfc_checker.sv -----
// ---------------------------------------------------------------------------
// Supply link frame controller: port checker
// Watches the result channel of the top level over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "supply_link_frame_controller_unit_macros.svh"

module slfc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       tx_valid,
	input wire logic [7:0] tx_byte,
	input wire logic       tx_last,
	input wire logic       main_enable,
	input wire logic       simmer_supply_on,
	input wire logic       hv_supply_on
);

	// stalled result holds
	`SLFC_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(tx_byte) && $stable(tx_last))

	// a request with no reply byte yields exactly one, empty result
	`SLFC_ASSERT_IMPL(a_silent_single, clk, arst_n, out_valid && !tx_valid, tx_last && tx_byte == 8'd0)

	// supplies only run with main on
	`SLFC_ASSERT_IMPL(a_main_gate, clk, arst_n, out_valid && (hv_supply_on || simmer_supply_on), main_enable)

endmodule

bind supply_link_frame_controller_unit slfc_checker u_slfc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.tx_valid         (out_ch.tx_valid),
	.tx_byte          (out_ch.tx_byte),
	.tx_last          (out_ch.tx_last),
	.main_enable      (out_ch.main_enable),
	.simmer_supply_on (out_ch.simmer_supply_on),
	.hv_supply_on     (out_ch.hv_supply_on)
);

`default_nettype wire
